// ===== sv/iwy_pkg.sv =====
// Shared types, constants and helper functions for the ISO week-year pipeline.
// Used by every module of iso_week_year_from_day_number; no dependencies.
`timescale 1ns / 1ps

package iwy_pkg;

    localparam int NumStages = 12;
    localparam int DayW      = 32;
    localparam int YearW     = 24;

    localparam int StgIn   = 0;
    localparam int StgZp   = 1;
    localparam int StgQ0   = 2;
    localparam int StgRem  = 3;
    localparam int StgDoe  = 4;
    localparam int StgDiv  = 5;
    localparam int StgT    = 6;
    localparam int StgYoe  = 7;
    localparam int StgY365 = 8;
    localparam int StgDoy  = 9;
    localparam int StgMon  = 10;
    localparam int StgOut  = 11;

    localparam int DaysPerEraI  = 146097;
    localparam int EpochShift   = 719468;
    localparam int EraBias      = 14695;
    localparam int EraYears     = 400;
    localparam int CentDays     = 36524;
    localparam int QuadYearDays = 1460;
    localparam int YearDays     = 365;
    localparam int CentYears    = 100;
    localparam int EraShift     = 24;
    localparam int EraHiLsb     = 10;
    localparam int QuadShift    = 29;
    localparam int YearShift    = 27;

    localparam logic [17:0] DaysPerEra = 18'(DaysPerEraI);
    localparam logic [32:0] ZpBias     =
        33'(longint'(EpochShift) + longint'(EraBias) * longint'(DaysPerEraI));
    localparam logic [16:0] EraRecip   =
        17'((longint'(1) << (EraShift + EraHiLsb)) / longint'(DaysPerEraI));
    localparam logic [18:0] DivRecip   =
        19'(((longint'(1) << QuadShift) + longint'(QuadYearDays) - 1) /
            longint'(QuadYearDays));
    localparam logic [24:0] YearBias   = 25'(EraBias * EraYears);

    localparam logic [3:0] MpDec = 4'd9;
    localparam logic [3:0] MpJan = 4'd10;
    localparam int         MonthCount = 12;

    typedef logic [NumStages-1:0] t_stage_vec;

    typedef struct packed {
        t_stage_vec en;
        t_stage_vec vld;
    } t_pipe_ctl;

    typedef struct packed {
        logic [17:0] doe;
        logic [14:0] q;
        logic        is_null;
    } t_era_beat;

    typedef struct packed {
        logic [8:0]  doy;
        logic [24:0] ybase;
        logic [2:0]  wd;
        logic        is_null;
    } t_doy_beat;

    // March-based day of year at which each month starts
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // residue mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [17:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) +
             6'(x[17:15]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
        return s3[2:0];
    endfunction

endpackage

// ===== sv/iwy_stage_ctl.sv =====
// Stage valid bits and load enables for the twelve-stage pipeline.
// Depends on iwy_pkg.
`timescale 1ns / 1ps

module iwy_stage_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    output iwy_pkg::t_pipe_ctl o_ctl,
    output logic               o_stall,
    output logic               o_valid
);
    import iwy_pkg::*;

    t_stage_vec r_vld;
    t_stage_vec n_vld;
    t_stage_vec w_rdy;
    t_stage_vec w_en;
    t_stage_vec w_fed;

    always_comb begin
        for (int k = 0; k < NumStages; k++) begin
            w_rdy[k] = !i_stall || ((r_vld | t_stage_vec'((1 << k) - 1)) != '1);
            w_fed[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            w_en[k]  = w_rdy[k] && w_fed[k];
            n_vld[k] = w_rdy[k] ? w_fed[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en  = w_en;
    assign o_ctl.vld = r_vld;
    assign o_stall   = !w_rdy[StgIn];
    assign o_valid   = r_vld[StgOut];

`ifndef NO_ASSERTIONS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("upstream stalled while a stage is empty");

    a_beat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_vld) == $countones($past(r_vld)) +
            int'($past(i_valid && !o_stall)) - int'($past(o_valid && !i_stall))))
        else $error("beat lost or duplicated in pipeline");
`endif

endmodule

// ===== sv/iwy_era_split.sv =====
// Input register and era split: day count to day-of-era and era index.
// Stages in, zp, q0, rem, doe. Depends on iwy_pkg.
`timescale 1ns / 1ps

module iwy_era_split (
    input  logic                      i_clk,
    input  iwy_pkg::t_pipe_ctl        i_ctl,
    input  logic signed [iwy_pkg::DayW-1:0] i_day_number,
    input  logic                      i_in_null,
    output iwy_pkg::t_era_beat        o_beat
);
    import iwy_pkg::*;

    logic [DayW-1:0] r0_day;
    logic            r0_null;
    logic [32:0]     r1_zp;
    logic            r1_null;
    logic [14:0]     r2_q0;
    logic [18:0]     r2_zlo;
    logic            r2_null;
    logic [14:0]     r3_q0;
    logic [18:0]     r3_rem;
    logic            r3_null;
    logic [17:0]     r4_doe;
    logic [14:0]     r4_q;
    logic            r4_null;

    logic [32:0] n1_zp;
    logic [39:0] w_eprod;
    logic [32:0] w_qd;
    logic        w_ge;
    logic [18:0] w_rem_sub;

    assign n1_zp     = {r0_day[DayW-1], r0_day} + ZpBias;
    assign w_eprod   = 40'(r1_zp[32:EraHiLsb]) * 40'(EraRecip);
    assign w_qd      = 33'(r2_q0) * 33'(DaysPerEra);
    assign w_ge      = r3_rem >= {1'b0, DaysPerEra};
    assign w_rem_sub = r3_rem - {1'b0, DaysPerEra};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[StgIn]) begin
            r0_day  <= i_day_number;
            r0_null <= i_in_null;
        end
        if (i_ctl.en[StgZp]) begin
            r1_zp   <= n1_zp;
            r1_null <= r0_null;
        end
        if (i_ctl.en[StgQ0]) begin
            r2_q0   <= w_eprod[EraShift+14:EraShift];
            r2_zlo  <= r1_zp[18:0];
            r2_null <= r1_null;
        end
        if (i_ctl.en[StgRem]) begin
            r3_q0   <= r2_q0;
            r3_rem  <= r2_zlo - w_qd[18:0];
            r3_null <= r2_null;
        end
        if (i_ctl.en[StgDoe]) begin
            r4_doe  <= w_ge ? w_rem_sub[17:0] : r3_rem[17:0];
            r4_q    <= r3_q0 + 15'(w_ge);
            r4_null <= r3_null;
        end
    end

    assign o_beat.doe     = r4_doe;
    assign o_beat.q       = r4_q;
    assign o_beat.is_null = r4_null;

`ifndef NO_ASSERTIONS
    a_era_rem_range: assert property (@(posedge i_clk)
        i_ctl.vld[StgRem] |-> (r3_rem < {DaysPerEra, 1'b0}))
        else $error("era quotient estimate off by more than one");
`endif

endmodule

// ===== sv/iwy_year_of_era.sv =====
// Day-of-era to year-of-era, day of March-based year and ISO weekday.
// Stages div, t, yoe, y365, doy. Depends on iwy_pkg.
`timescale 1ns / 1ps

module iwy_year_of_era (
    input  logic               i_clk,
    input  iwy_pkg::t_pipe_ctl i_ctl,
    input  iwy_pkg::t_era_beat i_beat,
    output iwy_pkg::t_doy_beat o_beat
);
    import iwy_pkg::*;

    logic [6:0]  r5_a;
    logic [2:0]  r5_b;
    logic        r5_c;
    logic [17:0] r5_doe;
    logic [14:0] r5_q;
    logic [2:0]  r5_wd;
    logic        r5_null;
    logic [17:0] r6_t;
    logic [17:0] r6_doe;
    logic [23:0] r6_q400;
    logic [2:0]  r6_wd;
    logic        r6_null;
    logic [8:0]  r7_yoe;
    logic [17:0] r7_doe;
    logic [23:0] r7_q400;
    logic [2:0]  r7_wd;
    logic        r7_null;
    logic [16:0] r8_y365;
    logic [6:0]  r8_yq;
    logic [17:0] r8_doe;
    logic [24:0] r8_ybase;
    logic [2:0]  r8_wd;
    logic        r8_null;
    logic [8:0]  r9_doy;
    logic [24:0] r9_ybase;
    logic [2:0]  r9_wd;
    logic        r9_null;

    logic [36:0] w_aprod;
    logic [36:0] w_yprod;
    logic [2:0]  n5_b;
    logic [1:0]  n8_hund;
    logic [17:0] n9_doy;

    assign w_aprod = 37'(i_beat.doe) * 37'(DivRecip);
    assign w_yprod = 37'(r6_t) * 37'(DivRecip);
    assign n9_doy  = r8_doe - 18'(r8_y365) - 18'(r8_yq);

    always_comb begin
        n5_b    = '0;
        n8_hund = '0;
        for (int k = 1; k <= 4; k++) begin
            n5_b = n5_b + 3'(i_beat.doe >= 18'(k * CentDays));
        end
        for (int k = 1; k <= 3; k++) begin
            n8_hund = n8_hund + 2'(r7_yoe >= 9'(k * CentYears));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[StgDiv]) begin
            r5_a    <= w_aprod[QuadShift+6:QuadShift];
            r5_b    <= n5_b;
            r5_c    <= i_beat.doe == (DaysPerEra - 18'd1);
            r5_doe  <= i_beat.doe;
            r5_q    <= i_beat.q;
            r5_wd   <= mod7(i_beat.doe + 18'd2) + 3'd1;
            r5_null <= i_beat.is_null;
        end
        if (i_ctl.en[StgT]) begin
            r6_t    <= r5_doe - 18'(r5_a) + 18'(r5_b) - 18'(r5_c);
            r6_doe  <= r5_doe;
            r6_q400 <= 24'(r5_q) * 24'(EraYears);
            r6_wd   <= r5_wd;
            r6_null <= r5_null;
        end
        if (i_ctl.en[StgYoe]) begin
            r7_yoe  <= w_yprod[YearShift+8:YearShift];
            r7_doe  <= r6_doe;
            r7_q400 <= r6_q400;
            r7_wd   <= r6_wd;
            r7_null <= r6_null;
        end
        if (i_ctl.en[StgY365]) begin
            r8_y365  <= 17'(r7_yoe) * 17'(YearDays);
            r8_yq    <= 7'(r7_yoe[8:2]) - 7'(n8_hund);
            r8_doe   <= r7_doe;
            r8_ybase <= 25'(r7_q400) + 25'(r7_yoe) - YearBias;
            r8_wd    <= r7_wd;
            r8_null  <= r7_null;
        end
        if (i_ctl.en[StgDoy]) begin
            r9_doy   <= n9_doy[8:0];
            r9_ybase <= r8_ybase;
            r9_wd    <= r8_wd;
            r9_null  <= r8_null;
        end
    end

    assign o_beat.doy     = r9_doy;
    assign o_beat.ybase   = r9_ybase;
    assign o_beat.wd      = r9_wd;
    assign o_beat.is_null = r9_null;

`ifndef NO_ASSERTIONS
    a_doy_range: assert property (@(posedge i_clk)
        i_ctl.vld[StgDoy] |-> (r9_doy < 9'(YearDays + 1)))
        else $error("day of year out of range");
`endif

endmodule

// ===== sv/iwy_iso_resolve.sv =====
// Month and day from March-based day of year, then ISO week-year choice.
// Stages mon and out (result register). Depends on iwy_pkg.
`timescale 1ns / 1ps

module iwy_iso_resolve (
    input  logic                       i_clk,
    input  iwy_pkg::t_pipe_ctl         i_ctl,
    input  iwy_pkg::t_doy_beat         i_beat,
    output logic signed [iwy_pkg::YearW-1:0] o_iso_year,
    output logic                       o_out_null
);
    import iwy_pkg::*;

    logic [3:0]       r10_mp;
    logic [4:0]       r10_mday;
    logic [24:0]      r10_ybase;
    logic [2:0]       r10_wd;
    logic             r10_null;
    logic [YearW-1:0] r11_year;
    logic             r11_null;

    logic [3:0]  n10_mp;
    logic [8:0]  n10_mday;
    logic [24:0] w_year;
    logic [24:0] w_iso;
    logic        w_next;
    logic        w_prev;

    always_comb begin
        n10_mp = '0;
        for (int k = 1; k < MonthCount; k++) begin
            n10_mp = n10_mp + 4'(i_beat.doy >= month_start(4'(k)));
        end
        n10_mday = i_beat.doy - month_start(n10_mp) + 9'd1;
    end

    always_comb begin
        w_year = r10_ybase + 25'(r10_mp >= MpJan);
        w_next = (r10_mp == MpDec) && (r10_mday >= 5'd29) &&
                 (6'(r10_mday) >= 6'(r10_wd) + 6'd28);
        w_prev = (r10_mp == MpJan) && (r10_mday <= 5'd3) &&
                 (4'(r10_wd) >= 4'(r10_mday) + 4'd4);
        w_iso  = w_year;
        if (w_next) begin
            w_iso = w_year + 25'd1;
        end else if (w_prev) begin
            w_iso = w_year - 25'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[StgMon]) begin
            r10_mp    <= n10_mp;
            r10_mday  <= n10_mday[4:0];
            r10_ybase <= i_beat.ybase;
            r10_wd    <= i_beat.wd;
            r10_null  <= i_beat.is_null;
        end
        if (i_ctl.en[StgOut]) begin
            r11_year <= r10_null ? '0 : w_iso[YearW-1:0];
            r11_null <= r10_null;
        end
    end

    assign o_iso_year = r11_year;
    assign o_out_null = r11_null;

`ifndef NO_ASSERTIONS
    a_mday_range: assert property (@(posedge i_clk)
        i_ctl.vld[StgMon] |-> ((r10_mday >= 5'd1) && (r10_mp < 4'(MonthCount))))
        else $error("month or day of month out of range");
`endif

endmodule

// ===== sv/iso_week_year_from_day_number.sv =====
// Top level: ISO 8601 week-numbering year of a signed day count.
// Depends on iwy_pkg, iwy_stage_ctl, iwy_era_split, iwy_year_of_era, iwy_iso_resolve.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_day_number[31:0] s, i_in_null
//   result    out        o_valid / i_stall   o_iso_year[23:0] s, o_out_null
//
// One beat per cycle sustained while o_stall is low; o_valid marks a beat that has passed
// through the twelve register stages of the datapath (at most one multiply per stage).
// Reset clears the stage valid bits only; payload registers are not reset.
// i_stall holds the pipeline while empty stages still fill, so bubbles close up.
// o_stall rises only when all twelve stages hold a beat and i_stall is high.
`timescale 1ns / 1ps

module iso_week_year_from_day_number (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [iwy_pkg::DayW-1:0]  i_day_number,
    input  logic                             i_in_null,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [iwy_pkg::YearW-1:0] o_iso_year,
    output logic                             o_out_null
);
    import iwy_pkg::*;

    t_pipe_ctl w_ctl;
    t_era_beat w_era;
    t_doy_beat w_doy;

    iwy_stage_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_ctl   (w_ctl),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    iwy_era_split u_era (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_day_number (i_day_number),
        .i_in_null    (i_in_null),
        .o_beat       (w_era)
    );

    iwy_year_of_era u_yoe (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_beat (w_era),
        .o_beat (w_doy)
    );

    iwy_iso_resolve u_iso (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_beat     (w_doy),
        .o_iso_year (o_iso_year),
        .o_out_null (o_out_null)
    );

endmodule
